>>> src/bpc_pkg.sv
// shared types and constants for the button press classifier
package bpc_pkg;

  // event codes carried on the result stream
  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } event_e;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;

  localparam int unsigned LimitBits = 16;

  // reset values of the configuration registers
  localparam logic [LimitBits-1:0] DebounceReset = 16'd50;
  localparam logic [LimitBits-1:0] WindowReset   = 16'd400;
  localparam logic [LimitBits-1:0] LongReset     = 16'd3000;

  // configuration as seen by the classifier core
  typedef struct packed {
    logic [LimitBits-1:0] debounce_limit_ms;
    logic [LimitBits-1:0] double_window_ms;
    logic [LimitBits-1:0] long_limit_ms;
  } cfg_t;

endpackage

>>> src/bpc_core.sv
// debounce and press classification state with its per-tick update
module bpc_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpc_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic          raw_level_i,
  input  logic [7:0]    elapsed_ms_i,
  output logic          ev_valid_o,
  output logic [1:0]    ev_code_o
);
  import bpc_pkg::*;

  localparam int unsigned CmpBits = (TIMER_BITS > LimitBits) ? TIMER_BITS : LimitBits;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  logic                  prior_raw_q, prior_raw_d;
  logic                  stable_q, stable_d;
  logic [TIMER_BITS-1:0] settle_q, settle_d;
  logic [TIMER_BITS-1:0] hold_q, hold_d;
  logic [TIMER_BITS-1:0] gap_q, gap_d;
  logic [1:0]            tally_q, tally_d;
  logic                  done_q, done_d;

  logic [TIMER_BITS-1:0] settle_base, hold_base;
  logic [TIMER_BITS:0]   settle_sum, hold_sum, gap_sum;
  logic [TIMER_BITS-1:0] settle_sat, hold_sat, gap_sat;
  logic                  settled, press;
  logic [1:0]            tally_inc;
  event_e                ev_code;

  // saturating timer sums
  assign settle_base = (raw_level_i != prior_raw_q) ? '0 : settle_q;
  assign settle_sum  = {1'b0, settle_base} + (TIMER_BITS+1)'(elapsed_ms_i);
  assign settle_sat  = settle_sum[TIMER_BITS] ? TimerMax : settle_sum[TIMER_BITS-1:0];

  assign press       = stable_q & ~raw_level_i;
  assign hold_base   = press ? '0 : hold_q;
  assign hold_sum    = {1'b0, hold_base} + (TIMER_BITS+1)'(elapsed_ms_i);
  assign hold_sat    = hold_sum[TIMER_BITS] ? TimerMax : hold_sum[TIMER_BITS-1:0];

  assign gap_sum     = {1'b0, gap_q} + (TIMER_BITS+1)'(elapsed_ms_i);
  assign gap_sat     = gap_sum[TIMER_BITS] ? TimerMax : gap_sum[TIMER_BITS-1:0];

  assign settled   = CmpBits'(settle_sat) >= CmpBits'(cfg_i.debounce_limit_ms);
  assign tally_inc = tally_q + 2'd1;

  // next state and event for one tick
  always_comb begin
    prior_raw_d = raw_level_i;
    settle_d    = settle_sat;
    stable_d    = stable_q;
    hold_d      = hold_q;
    gap_d       = gap_q;
    tally_d     = tally_q;
    done_d      = done_q;
    ev_valid_o  = 1'b0;
    ev_code     = EV_SINGLE;
    if (settled) begin
      stable_d = raw_level_i;
      // debounced press
      if (press) begin
        hold_d = '0;
        done_d = 1'b0;
        tally_d = tally_inc;
        if (tally_inc == 2'd1) begin
          gap_d = '0;
        end
        if (tally_inc >= 2'd2) begin
          ev_valid_o = 1'b1;
          ev_code    = EV_DOUBLE;
          tally_d    = 2'd0;
          done_d     = 1'b1;
        end
      end
      if (!raw_level_i) begin
        // held down: long press check
        hold_d = hold_sat;
        if (!done_d && (tally_d != 2'd0) &&
            (CmpBits'(hold_sat) >= CmpBits'(cfg_i.long_limit_ms))) begin
          ev_valid_o = 1'b1;
          ev_code    = EV_LONG;
          done_d     = 1'b1;
          tally_d    = 2'd0;
        end
      end else if ((tally_q == 2'd1) && !done_q) begin
        // released after one press: quiet gap check
        gap_d = gap_sat;
        if (CmpBits'(gap_sat) >= CmpBits'(cfg_i.double_window_ms)) begin
          ev_valid_o = 1'b1;
          ev_code    = EV_SINGLE;
          tally_d    = 2'd0;
          done_d     = 1'b1;
        end
      end
    end
  end

  assign ev_code_o = ev_code;

  // state registers, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_raw_q <= 1'b1;
      stable_q    <= 1'b1;
      settle_q    <= '0;
      hold_q      <= '0;
      gap_q       <= '0;
      tally_q     <= 2'd0;
      done_q      <= 1'b0;
    end else if (step_i) begin
      prior_raw_q <= prior_raw_d;
      stable_q    <= stable_d;
      settle_q    <= settle_d;
      hold_q      <= hold_d;
      gap_q       <= gap_d;
      tally_q     <= tally_d;
      done_q      <= done_d;
    end
  end

endmodule

>>> src/button_press_classifier.sv
// top level of the button press classifier: stream ports, config registers, item stages
//
//  channel   direction  payload                                   handshake
//  s_axis    in         tdata[0] raw_level, tdata[8:1] elapsed_ms  tvalid/tready
//  m_axis    out        tdata[1:0] event_code                     tvalid/tready
//  cfg       in         cfg_index_i, cfg_data_i                   cfg_valid_i/cfg_ready_o
//
// one tick per cycle while m_axis does not stall: an item is registered in the input stage,
// then classified by the core, and its event, if any, lands in the output register.
// ticks that give no event are absorbed without a result item.
// reset restores the default limits and the released button state.
// a stall on m_axis holds the input stage only while a result is still waiting.
module button_press_classifier #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] raw_level, [8:1] elapsed_ms, [15:9] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] event_code, [7:2] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bpc_pkg::*;

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic       raw_q;
  logic [7:0] elapsed_q;
  logic       out_valid_q;
  logic [1:0] out_code_q;
  logic       step;
  logic       ev_valid;
  logic [1:0] ev_code;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit_ms <= DebounceReset;
      cfg_q.double_window_ms  <= WindowReset;
      cfg_q.long_limit_ms     <= LongReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE: cfg_q.debounce_limit_ms <= cfg_data_i;
        REG_WINDOW:   cfg_q.double_window_ms  <= cfg_data_i;
        REG_LONG:     cfg_q.long_limit_ms     <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // stage handshake
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      raw_q     <= s_axis_tdata[0];
      elapsed_q <= s_axis_tdata[8:1];
    end
  end

  bpc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .raw_level_i (raw_q),
    .elapsed_ms_i(elapsed_q),
    .ev_valid_o  (ev_valid),
    .ev_code_o   (ev_code)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= ev_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && ev_valid) begin
      out_code_q <= ev_code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_code_q};

endmodule
